FILE: rtl/npcs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the nearest palette color search.
// No dependencies.
package npcs_pkg;

    localparam int COLOR_W = 8;
    localparam int INDEX_W = 8;
    localparam int DIST_W  = 10;
    localparam int ENTRY_W = 3 * COLOR_W;

    localparam logic [DIST_W-1:0] MAX_DIST = 10'd765;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    function automatic logic [COLOR_W-1:0] abs_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: rtl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// Nearest palette color search, Manhattan distance over RGB; uses npcs_pkg, npcs_ram.
// Write word: stored in the palette, ready again the next cycle; no result.
// Query word: one palette read per cycle from the RAM port; the scan stops after the
// last slot or at the first exact match, then the result waits for the output register.
// One word in flight at a time; the result register lets a write be taken while it waits.
// aresetn (synchronous, active low) clears control state; palette contents are not cleared.
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [0:0] s_opcode,
    input  logic [7:0] s_entry_index,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_match_index
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_ENTRIES - 1);
    localparam logic [npcs_pkg::INDEX_W:0] ENTRY_LIMIT =
        (npcs_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);

    npcs_pkg::state_t state_reg, state_next;

    logic [npcs_pkg::COLOR_W-1:0] q_red_reg, q_green_reg, q_blue_reg;
    logic [npcs_pkg::COLOR_W-1:0] q_red_next, q_green_next, q_blue_next;
    logic [AW-1:0]                issue_idx_reg, issue_idx_next;
    logic                         issue_active_reg, issue_active_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic [AW-1:0]                rd_idx_reg, rd_idx_next;
    logic                         rd_last_reg, rd_last_next;
    logic [npcs_pkg::DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [AW-1:0]                best_idx_reg, best_idx_next;
    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   m_match_index_reg, m_match_index_next;

    logic                         accept;
    logic                         is_query;
    logic                         wr_en;
    logic                         rd_en;
    logic [npcs_pkg::ENTRY_W-1:0] rd_data;
    logic [npcs_pkg::DIST_W-1:0]  cur_dist;
    logic                         scan_done;
    logic                         out_free;

    assign accept   = s_valid && s_ready;
    assign is_query = (s_opcode == npcs_pkg::OP_QUERY);
    assign wr_en    = accept && !is_query && ({1'b0, s_entry_index} < ENTRY_LIMIT);
    assign out_free = !m_valid_reg || m_ready;

    npcs_ram #(
        .WIDTH (npcs_pkg::ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_entry_index[AW-1:0]),
        .wr_data ({s_red, s_green, s_blue}),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg),
        .rd_data (rd_data)
    );

    assign cur_dist =
        {2'b00, npcs_pkg::abs_diff(rd_data[23:16], q_red_reg)} +
        {2'b00, npcs_pkg::abs_diff(rd_data[15:8], q_green_reg)} +
        {2'b00, npcs_pkg::abs_diff(rd_data[7:0], q_blue_reg)};

    assign scan_done = rd_valid_reg && ((cur_dist == '0) || rd_last_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            npcs_pkg::ST_IDLE: begin
                if (accept && is_query) begin
                    state_next = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = npcs_pkg::ST_HOLD;
                end
            end
            npcs_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = npcs_pkg::ST_IDLE;
                end
            end
            default: state_next = npcs_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready            = 1'b0;
        rd_en              = 1'b0;
        q_red_next         = q_red_reg;
        q_green_next       = q_green_reg;
        q_blue_next        = q_blue_reg;
        issue_idx_next     = issue_idx_reg;
        issue_active_next  = issue_active_reg;
        rd_valid_next      = 1'b0;
        rd_idx_next        = rd_idx_reg;
        rd_last_next       = rd_last_reg;
        best_dist_next     = best_dist_reg;
        best_idx_next      = best_idx_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_match_index_next = m_match_index_reg;
        case (state_reg)
            npcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept && is_query) begin
                    q_red_next        = s_red;
                    q_green_next      = s_green;
                    q_blue_next       = s_blue;
                    issue_idx_next    = '0;
                    issue_active_next = 1'b1;
                    best_dist_next    = npcs_pkg::MAX_DIST;
                    best_idx_next     = '0;
                end
            end
            npcs_pkg::ST_SCAN: begin
                if (issue_active_reg) begin
                    rd_en             = 1'b1;
                    rd_valid_next     = 1'b1;
                    rd_idx_next       = issue_idx_reg;
                    rd_last_next      = (issue_idx_reg == LAST_IDX);
                    issue_idx_next    = issue_idx_reg + 1'b1;
                    issue_active_next = (issue_idx_reg != LAST_IDX);
                end
                if (rd_valid_reg) begin
                    if (cur_dist == '0) begin
                        best_idx_next = rd_idx_reg;
                    end else if (cur_dist < best_dist_reg) begin
                        best_idx_next  = rd_idx_reg;
                        best_dist_next = cur_dist;
                    end
                end
                if (scan_done) begin
                    rd_valid_next     = 1'b0;
                    issue_active_next = 1'b0;
                end
            end
            npcs_pkg::ST_HOLD: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_match_index_next = 8'(best_idx_reg);
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= npcs_pkg::ST_IDLE;
            issue_active_reg <= 1'b0;
            rd_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            issue_active_reg <= issue_active_next;
            rd_valid_reg     <= rd_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_red_reg         <= q_red_next;
        q_green_reg       <= q_green_next;
        q_blue_reg        <= q_blue_next;
        issue_idx_reg     <= issue_idx_next;
        rd_idx_reg        <= rd_idx_next;
        rd_last_reg       <= rd_last_next;
        best_dist_reg     <= best_dist_next;
        best_idx_reg      <= best_idx_next;
        m_match_index_reg <= m_match_index_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_match_index = m_match_index_reg;

`ifndef SYNTHESIS
    a_rd_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == npcs_pkg::ST_SCAN))
        else $error("palette read data outside a scan");

    a_best_never_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == npcs_pkg::ST_SCAN) |-> (best_dist_reg != '0))
        else $error("scan kept running after an exact match");

    a_result_from_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == npcs_pkg::ST_HOLD))
        else $error("result word raised outside the hold state");

    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == npcs_pkg::ST_SCAN) |-> !s_ready)
        else $error("input word taken during a scan");
`endif

endmodule

FILE: rtl/npcs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
